// ===== design/set_assoc_writeback_cache_lru_unit_macros.svh =====
// Assertion macros for the set-associative write-back cache tag unit.
`ifndef SET_ASSOC_WRITEBACK_CACHE_LRU_UNIT_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LRU_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SAWBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAWBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sawbc_pkg.sv =====
// Shared types and constants of the set-associative write-back cache tag unit.
package sawbc_pkg;

    localparam int ADDR_W = 32;
    localparam int OP_W   = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ      = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE     = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITEBACK = 2'd2;

    // Request word
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
    } req_t;

    // Result word
    typedef struct packed {
        logic              hit;
        logic              allocated;
        logic              evict_dirty;
        logic [ADDR_W-1:0] evict_address;
    } rsp_t;

endpackage

// ===== design/set_assoc_writeback_cache_lru_unit.sv =====
// Set-associative write-back cache tag store with LRU replacement.
//
//  Channel | Direction | Handshake              | Word
//  s_      | in        | s_valid / s_ready      | s_data  (operation, address)
//  m_      | out       | m_valid / m_ready      | m_data  (hit, allocated, evict_*)
//  cfg_    | in        | cfg_write_enable       | cfg_write_data (write_allocate)
//
// When SET_COUNT is a power of two, the set row is read from the tag and state memories
// at the accept edge, then compared, updated and written back.
// Otherwise the block number is split first: a reciprocal multiply for the tag (ST_DIV),
// then a multiply-subtract for the set (ST_REM), then the memory read (ST_READ).
// After reset a clearing pass over all SET_COUNT sets initializes the state memory;
// s_ready stays low meanwhile, configuration writes are taken.
// A new word is accepted while a result waits in the output register; the compare
// stage holds until that register is free.

`include "set_assoc_writeback_cache_lru_unit_macros.svh"

module set_assoc_writeback_cache_lru_unit #(
    parameter int SET_COUNT        = 64,
    parameter int WAY_COUNT        = 4,
    parameter int BLOCK_BYTES_LOG2 = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_write_enable,
    input  logic              cfg_write_data,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  sawbc_pkg::req_t   s_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output sawbc_pkg::rsp_t   m_data
);

    localparam int  BLK_W     = sawbc_pkg::ADDR_W - BLOCK_BYTES_LOG2;
    localparam int  SET_LOG2  = $clog2(SET_COUNT);
    localparam int  SET_W     = (SET_COUNT > 1) ? SET_LOG2 : 1;
    localparam int  TAG_W     = BLK_W - ($clog2(SET_COUNT + 1) - 1);
    localparam int  WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
    localparam int  RANK_W    = WAY_W;
    localparam bit  DIVIDE    = (SET_COUNT & (SET_COUNT - 1)) != 0;
    localparam int  MAGIC_W   = BLK_W + 1;
    localparam int  PROD_W    = BLK_W + MAGIC_W;
    localparam int  DIV_SHIFT = BLK_W + SET_LOG2;
    localparam longint DIV_MAGIC = ((longint'(1) << DIV_SHIFT) + longint'(SET_COUNT) - 1) /
                                   longint'(SET_COUNT);
    localparam logic [MAGIC_W-1:0] DIV_MAGIC_C = MAGIC_W'(DIV_MAGIC);
    localparam logic [SET_W-1:0] SET_LAST   = SET_W'(SET_COUNT - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_READ,
        ST_CMP
    } state_t;

    // One row per set: per-way valid, dirty and LRU rank
    typedef struct packed {
        logic [WAY_COUNT-1:0][RANK_W-1:0] rank;
        logic [WAY_COUNT-1:0]             dirty;
        logic [WAY_COUNT-1:0]             valid;
    } meta_t;

    typedef logic [WAY_COUNT-1:0][TAG_W-1:0] tag_row_t;

    // Memories
    meta_t    meta_mem [SET_COUNT];
    tag_row_t tag_mem  [SET_COUNT];

    state_t                  state_reg;
    logic                    wa_reg;
    logic [sawbc_pkg::OP_W-1:0] op_reg;
    logic [SET_W-1:0]        set_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [SET_W-1:0]        clr_cnt_reg;
    logic [BLK_W-1:0]        blk_reg;
    logic                    m_valid_reg;
    sawbc_pkg::rsp_t         m_data_reg;
    meta_t                   rd_meta_reg;
    tag_row_t                rd_tags_reg;

    logic                    s_fire;
    logic [BLK_W-1:0]        in_blk;
    logic [SET_W-1:0]        in_set;
    logic [TAG_W-1:0]        in_tag;
    logic                    rd_en;
    logic [SET_W-1:0]        rd_addr;

    logic [PROD_W-1:0]       div_prod;
    logic [TAG_W-1:0]        div_quot;
    logic [SET_W-1:0]        div_rem;

    logic [WAY_COUNT-1:0]    match;
    logic                    hit_found;
    logic [WAY_W-1:0]        hit_way;
    logic                    inv_found;
    logic [WAY_W-1:0]        inv_way;
    logic [WAY_W-1:0]        lru_way;
    logic [WAY_W-1:0]        victim;
    logic [WAY_W-1:0]        touch_way;
    logic [RANK_W-1:0]       old_rank;
    logic                    op_ok;
    logic                    fill;
    logic                    touch;
    logic                    ev_dirty;
    logic [BLK_W-1:0]        ev_blk;
    meta_t                   meta_next;
    tag_row_t                tag_row_next;
    meta_t                   clear_row;
    sawbc_pkg::rsp_t         rsp_next;
    logic                    commit;
    logic                    meta_we;
    logic [SET_W-1:0]        meta_addr;
    meta_t                   meta_wdata;
    logic                    tag_we;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Address split for a power-of-two set count
    assign in_blk = s_data.address[sawbc_pkg::ADDR_W-1:BLOCK_BYTES_LOG2];
    assign in_set = SET_W'(in_blk & BLK_W'(SET_COUNT - 1));
    assign in_tag = TAG_W'(in_blk >> SET_LOG2);

    // Constant divide: reciprocal multiply for the tag, multiply-subtract for the set
    assign div_prod = PROD_W'(blk_reg) * PROD_W'(DIV_MAGIC_C);
    assign div_quot = TAG_W'(div_prod >> DIV_SHIFT);
    assign div_rem  = SET_W'(blk_reg - BLK_W'(BLK_W'(tag_reg) * BLK_W'(SET_COUNT)));

    // Memory read port
    assign rd_en   = (s_fire && !DIVIDE) || (state_reg == ST_READ);
    assign rd_addr = (state_reg == ST_IDLE) ? in_set : set_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_meta_reg <= meta_mem[rd_addr];
            rd_tags_reg <= tag_mem[rd_addr];
        end
    end

    // Way lookup and victim choice
    always_comb begin
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            match[w] = rd_meta_reg.valid[w] && (rd_tags_reg[w] == tag_reg);
            if (match[w]) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!rd_meta_reg.valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(w);
            end
            if (rd_meta_reg.rank[w] == '0) begin
                lru_way = WAY_W'(w);
            end
        end
        victim = inv_found ? inv_way : lru_way;
    end

    // Access decision
    always_comb begin
        op_ok = (op_reg == sawbc_pkg::OP_READ) || (op_reg == sawbc_pkg::OP_WRITE) ||
                (op_reg == sawbc_pkg::OP_WRITEBACK);
        fill  = op_ok && !hit_found && ((op_reg != sawbc_pkg::OP_WRITE) || wa_reg);
        touch = (op_ok && hit_found) || fill;
        touch_way = hit_found ? hit_way : victim;
        old_rank  = rd_meta_reg.rank[touch_way];
        ev_dirty  = fill && rd_meta_reg.valid[victim] && rd_meta_reg.dirty[victim];
        ev_blk    = BLK_W'(sawbc_pkg::ADDR_W'(rd_tags_reg[victim]) *
                           sawbc_pkg::ADDR_W'(SET_COUNT)) + BLK_W'(set_reg);
    end

    // Row update: LRU touch, valid and dirty
    always_comb begin
        meta_next = rd_meta_reg;
        for (int k = 0; k < WAY_COUNT; k++) begin
            if ((WAY_W'(k) != touch_way) && (rd_meta_reg.rank[k] > old_rank)) begin
                meta_next.rank[k] = RANK_W'(rd_meta_reg.rank[k] - 1'b1);
            end
        end
        meta_next.rank[touch_way] = RANK_W'(WAY_COUNT - 1);
        if (op_reg != sawbc_pkg::OP_READ) begin
            meta_next.dirty[touch_way] = 1'b1;
        end
        if (fill) begin
            meta_next.valid[touch_way] = 1'b1;
            if (op_reg == sawbc_pkg::OP_READ) begin
                meta_next.dirty[touch_way] = 1'b0;
            end
        end
        tag_row_next         = rd_tags_reg;
        tag_row_next[victim] = tag_reg;
    end

    // Reset row: nothing valid, ranks equal to way index
    always_comb begin
        clear_row.valid = '0;
        clear_row.dirty = '0;
        for (int k = 0; k < WAY_COUNT; k++) begin
            clear_row.rank[k] = RANK_W'(k);
        end
    end

    // Result word
    always_comb begin
        rsp_next.hit           = op_ok && hit_found;
        rsp_next.allocated     = fill;
        rsp_next.evict_dirty   = ev_dirty;
        rsp_next.evict_address = ev_dirty ? {ev_blk, {BLOCK_BYTES_LOG2{1'b0}}} : '0;
    end

    // Memory write port
    assign commit     = (state_reg == ST_CMP) && (!m_valid_reg || m_ready);
    assign meta_we    = (state_reg == ST_CLEAR) || (commit && touch);
    assign meta_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign meta_wdata = (state_reg == ST_CLEAR) ? clear_row : meta_next;
    assign tag_we     = commit && fill;

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_addr] <= meta_wdata;
        end
        if (tag_we) begin
            tag_mem[set_reg] <= tag_row_next;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wa_reg <= 1'b1;
        end else if (cfg_write_enable) begin
            wa_reg <= cfg_write_data;
        end
    end

    // Control sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // a commit in the same cycle reloads the register instead
            if (m_valid_reg && m_ready && !commit) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= SET_W'(clr_cnt_reg + 1'b1);
                    if (clr_cnt_reg == SET_LAST) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        op_reg      <= s_data.operation;
                        set_reg     <= in_set;
                        tag_reg     <= in_tag;
                        blk_reg     <= in_blk;
                        state_reg   <= DIVIDE ? ST_DIV : ST_CMP;
                    end
                end
                ST_DIV: begin
                    tag_reg   <= div_quot;
                    state_reg <= ST_REM;
                end
                ST_REM: begin
                    set_reg   <= div_rem;
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (commit) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= rsp_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `SAWBC_ASSERT_IMPL(a_write_needs_slot, aclk, aresetn,
        (meta_we && (state_reg != ST_CLEAR)), (!m_valid_reg || m_ready),
        "state written back without a free result slot")
    `SAWBC_ASSERT_IMPL(a_evict_on_fill, aclk, aresetn,
        (m_valid_reg && m_data_reg.evict_dirty), (m_data_reg.allocated && !m_data_reg.hit),
        "dirty eviction without a miss fill")
    `SAWBC_ASSERT_IMPL(a_evict_addr_zero, aclk, aresetn,
        (m_valid_reg && !m_data_reg.evict_dirty), (m_data_reg.evict_address == '0),
        "victim address set without a dirty eviction")
    `SAWBC_ASSERT_NEXT(a_commit_result, aclk, aresetn,
        commit, (m_valid_reg && (state_reg == ST_IDLE)),
        "commit did not load the result register")

endmodule
